// ===== design/png_scanline_unfilter_core_defines.svh =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define PSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define PSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Sizes, filter codes, register indexes, the front-to-back request and the
// result record, and the range-clamp helpers for the configuration registers.
// ----------------------------------------------------------------------------
package psu_pkg;

  // Storage sizes
  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int ROW_LEN_W  = 14;
  localparam int PIX_W      = 4;
  localparam int COL_W      = $clog2(MAX_ROW_BYTES);
  localparam int LEN_EFF_W  = COL_W + 1;
  localparam int HIST_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // Queue sizes (powers of two, pointers wrap naturally)
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int OUT_DEPTH   = 2;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'b1;

  // Filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_e;

  // Highest legal filter byte
  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = BYTE_W'(FILT_PAETH);

  // Request from front to back: one data byte or one error
  typedef struct packed {
    logic              is_err;
    filt_e             filter;
    logic              first_row;
    logic              left_ok;
    logic              row_end;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] data;
  } psu_item_t;

  // One result
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte;
    logic              row_end;
    logic              bad_filter;
  } psu_result_t;

  // Clamp row length into 1..MAX_ROW_BYTES
  function automatic logic [LEN_EFF_W-1:0] eff_row_len(input logic [ROW_LEN_W-1:0] len);
    logic [LEN_EFF_W-1:0] r;
    if (len == '0) begin
      r = LEN_EFF_W'(1);
    end else if (int'(len) > MAX_ROW_BYTES) begin
      r = LEN_EFF_W'(MAX_ROW_BYTES);
    end else begin
      r = LEN_EFF_W'(len);
    end
    return r;
  endfunction

  // Clamp pixel bytes into 1..MAX_PIXEL_BYTES
  function automatic logic [PIX_W-1:0] eff_pix_bytes(input logic [PIX_W-1:0] pb);
    logic [PIX_W-1:0] r;
    if (pb == '0) begin
      r = PIX_W'(1);
    end else if (int'(pb) > MAX_PIXEL_BYTES) begin
      r = PIX_W'(MAX_PIXEL_BYTES);
    end else begin
      r = pb;
    end
    return r;
  endfunction

endpackage

// ===== design/psu_front.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter front end
// Accepts stream bytes, tracks row position and filter type, drops bytes
// after a bad filter, and issues data or error requests to the back end.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_core_defines.svh"

module psu_front import psu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [BYTE_W-1:0]    stream_byte_i,
  input  logic                 image_start_i,
  input  logic [ROW_LEN_W-1:0] row_length_i,
  input  logic [PIX_W-1:0]     pixel_bytes_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output psu_item_t            q_item_o
);

  logic [COL_W-1:0] column_q, column_d;
  filt_e            row_filter_q, row_filter_d;
  logic             awaiting_q, awaiting_d;
  logic             first_row_q, first_row_d;
  logic             halted_q, halted_d;

  logic                 accept;
  logic                 halt_v, await_v, first_v;
  logic [COL_W-1:0]     col_v;
  logic [LEN_EFF_W-1:0] col_next;
  logic [LEN_EFF_W-1:0] len_eff;
  logic [PIX_W-1:0]     pb_eff;
  logic                 row_end;

  assign accept  = push_i & ~q_full_i;
  assign len_eff = eff_row_len(row_length_i);
  assign pb_eff  = eff_pix_bytes(pixel_bytes_i);

  // Apply image start before classifying the byte
  assign halt_v   = halted_q & ~image_start_i;
  assign await_v  = awaiting_q | image_start_i;
  assign first_v  = first_row_q | image_start_i;
  assign col_v    = image_start_i ? '0 : column_q;
  assign col_next = {1'b0, col_v} + LEN_EFF_W'(1);
  assign row_end  = col_next >= len_eff;

  // Classify the byte and advance row position
  always_comb begin
    column_d     = column_q;
    row_filter_d = row_filter_q;
    awaiting_d   = awaiting_q;
    first_row_d  = first_row_q;
    halted_d     = halted_q;
    q_push_o     = 1'b0;

    q_item_o.is_err    = 1'b0;
    q_item_o.filter    = row_filter_q;
    q_item_o.first_row = first_v;
    q_item_o.left_ok   = {1'b0, col_v} >= LEN_EFF_W'(pb_eff);
    q_item_o.row_end   = row_end;
    q_item_o.col       = col_v;
    q_item_o.data      = stream_byte_i;

    if (accept) begin
      halted_d    = halt_v;
      awaiting_d  = await_v;
      first_row_d = first_v;
      column_d    = col_v;
      priority if (halt_v) begin
        // drop the byte
      end else if (await_v) begin
        if (stream_byte_i > FILT_MAX_CODE) begin
          halted_d        = 1'b1;
          q_push_o        = 1'b1;
          q_item_o.is_err = 1'b1;
        end else begin
          row_filter_d = filt_e'(stream_byte_i[2:0]);
          awaiting_d   = 1'b0;
          column_d     = '0;
        end
      end else begin
        q_push_o = 1'b1;
        if (row_end) begin
          column_d    = '0;
          awaiting_d  = 1'b1;
          first_row_d = 1'b0;
        end else begin
          column_d = col_next[COL_W-1:0];
        end
      end
    end
  end

  // Hold row state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_filter_q <= FILT_NONE;
      awaiting_q   <= 1'b1;
      first_row_q  <= 1'b1;
      halted_q     <= 1'b0;
    end else begin
      column_q     <= column_d;
      row_filter_q <= row_filter_d;
      awaiting_q   <= awaiting_d;
      first_row_q  <= first_row_d;
      halted_q     <= halted_d;
    end
  end

  // A halted stream waits for a new image, which always opens with a filter byte
  `PSU_ASSERT_IMP(a_halt_awaits, halted_q, awaiting_q, "halted without awaiting a filter byte")

  // A row-ending data byte leaves the front waiting for the next filter byte
  `PSU_ASSERT_NXT(a_row_end_await, q_push_o && !q_item_o.is_err && q_item_o.row_end,
                  awaiting_q && column_q == '0, "row end did not return to filter byte")

endmodule

// ===== design/psu_queue.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter request queue
// Short first-in first-out buffer that decouples the front and back ends.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_core_defines.svh"

module psu_queue import psu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  psu_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output psu_item_t item_o
);

  psu_item_t          mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Count follows a lone push
  `PSU_ASSERT_NXT(a_q_count_up, do_push && !do_pop, cnt_q == $past(cnt_q) + Q_CNT_W'(1),
                  "request queue count did not follow push")

endmodule

// ===== design/psu_back.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter back end
// Reads the prior row, forms the predictor, rebuilds each byte, keeps the
// byte histories, and buffers results for the output side.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_core_defines.svh"

module psu_back import psu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  psu_item_t         head_item_i,
  output logic              head_take_o,
  input  logic [PIX_W-1:0]  pixel_bytes_i,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [BYTE_W-1:0] pixel_byte_o,
  output logic              row_end_o,
  output logic              bad_filter_o
);

  // Prior row memory and its read stage
  logic [BYTE_W-1:0] prior_mem [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] rd_q;
  logic              byp_q;
  logic [BYTE_W-1:0] byp_data_q;

  // Compute stage
  logic              b_valid_q;
  psu_item_t         b_item_q;
  logic              b_adv;

  // Byte histories
  logic [BYTE_W-1:0] left_hist_q   [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] upleft_hist_q [MAX_PIXEL_BYTES];

  // Result queue
  psu_result_t          out_mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic                 out_full, out_pop;

  logic [PIX_W-1:0]      pb_eff;
  logic [HIST_IDX_W-1:0] hist_idx;
  logic [BYTE_W-1:0]     up, left, upleft, pred, value;
  logic [BYTE_W:0]       avg_sum;
  logic signed [BYTE_W+1:0] sa, sb, sc, d_pa, d_pb, d_pc, pa, pb, pc;
  logic [BYTE_W-1:0]     paeth;
  logic                  mem_we;
  psu_result_t           res;

  assign out_full    = out_cnt_q == OUT_CNT_W'(OUT_DEPTH);
  assign empty_o     = out_cnt_q == '0;
  assign out_pop     = pop_i & ~empty_o;
  assign b_adv       = b_valid_q & (~out_full | out_pop);
  assign head_take_o = head_valid_i & (~b_valid_q | b_adv);
  assign mem_we      = b_adv & ~b_item_q.is_err;

  // Pick neighbors; the prior row is forwarded when just written
  assign pb_eff   = eff_pix_bytes(pixel_bytes_i);
  assign hist_idx = HIST_IDX_W'(pb_eff - PIX_W'(1));
  assign up       = b_item_q.first_row ? '0 : (byp_q ? byp_data_q : rd_q);
  assign left     = b_item_q.left_ok ? left_hist_q[hist_idx] : '0;
  assign upleft   = (b_item_q.left_ok && !b_item_q.first_row) ? upleft_hist_q[hist_idx] : '0;

  // Paeth predictor
  assign sa   = $signed({2'b00, left});
  assign sb   = $signed({2'b00, up});
  assign sc   = $signed({2'b00, upleft});
  assign d_pa = sb - sc;
  assign d_pb = sa - sc;
  assign d_pc = sa + sb - $signed({1'b0, upleft, 1'b0});
  assign pa   = (d_pa < 0) ? -d_pa : d_pa;
  assign pb   = (d_pb < 0) ? -d_pb : d_pb;
  assign pc   = (d_pc < 0) ? -d_pc : d_pc;

  always_comb begin
    priority if (pa <= pb && pa <= pc) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = upleft;
    end
  end

  // Select predictor and rebuild the byte
  assign avg_sum = {1'b0, left} + {1'b0, up};

  always_comb begin
    unique case (b_item_q.filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
  end

  assign value = b_item_q.data + pred;

  always_comb begin
    if (b_item_q.is_err) begin
      res.pixel_byte = '0;
      res.row_end    = 1'b0;
      res.bad_filter = 1'b1;
    end else begin
      res.pixel_byte = value;
      res.row_end    = b_item_q.row_end;
      res.bad_filter = 1'b0;
    end
  end

  // Write back the rebuilt byte, read ahead for the next request
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      prior_mem[b_item_q.col] <= value;
    end
    if (head_take_o) begin
      rd_q       <= prior_mem[head_item_i.col];
      byp_q      <= mem_we && (b_item_q.col == head_item_i.col);
      byp_data_q <= value;
    end
  end

  // Load the compute stage
  always_ff @(posedge clk_i) begin
    if (head_take_o) begin
      b_item_q <= head_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (head_take_o) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  // Shift histories on each rebuilt byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i]   <= '0;
        upleft_hist_q[i] <= '0;
      end
    end else if (mem_we) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist_q[i]   <= left_hist_q[i-1];
        upleft_hist_q[i] <= upleft_hist_q[i-1];
      end
      left_hist_q[0]   <= value;
      upleft_hist_q[0] <= up;
    end
  end

  // Buffer results
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (b_adv) begin
        out_wr_q <= out_wr_q + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + OUT_PTR_W'(1);
      end
      if (b_adv && !out_pop) begin
        out_cnt_q <= out_cnt_q + OUT_CNT_W'(1);
      end else if (out_pop && !b_adv) begin
        out_cnt_q <= out_cnt_q - OUT_CNT_W'(1);
      end
    end
  end

  assign pixel_byte_o = out_mem_q[out_rd_q].pixel_byte;
  assign row_end_o    = out_mem_q[out_rd_q].row_end;
  assign bad_filter_o = out_mem_q[out_rd_q].bad_filter;

  // A stalled compute stage keeps its request
  `PSU_ASSERT_NXT(a_b_hold, b_valid_q && !b_adv, b_valid_q && $stable(b_item_q),
                  "stalled compute stage lost its request")

  // No result is written into a full result queue
  `PSU_ASSERT_IMP(a_out_no_ovf, out_full && !out_pop, !b_adv,
                  "result queue overflow")

endmodule

// ===== design/png_scanline_unfilter_core.sv =====
// ----------------------------------------------------------------------------
// PNG scanline unfilter core
// Rebuilds raw scanline bytes from a filtered, decompressed PNG byte stream.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and delivers one result per clock when
// neither side stalls. Each byte passes the front end (row tracking), a
// four-entry request queue, a compute stage that reads the previous row
// from a single-port-write, single-port-read byte memory, and a two-entry
// result queue. The one memory write and one memory read per cycle set
// the rate; a byte rebuilt in one cycle is forwarded to a read of the same
// column in the next. Filter bytes, and bytes dropped after a bad filter
// code, are taken from the input and give no result. The previous-row
// memory has no clearing pass: on the first row of an image its read data
// is not used.
// Write row_length and pixel_bytes only while the core is idle.
// ----------------------------------------------------------------------------

module png_scanline_unfilter_core import psu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input queue side
  input  logic                 push,
  output logic                 full,
  input  logic [BYTE_W-1:0]    stream_byte_i,
  input  logic                 image_start_i,
  // Result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    pixel_byte_o,
  output logic                 row_end_o,
  output logic                 bad_filter_o,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ROW_LEN_W-1:0] cfg_data_i
);

  logic [ROW_LEN_W-1:0] row_length_q;
  logic [PIX_W-1:0]     pixel_bytes_q;

  logic      fq_push, fq_full;
  psu_item_t fq_item;
  logic      bq_valid, bq_take;
  psu_item_t bq_item;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= ROW_LEN_W'(1);
      pixel_bytes_q <= PIX_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROW_LENGTH:  row_length_q  <= cfg_data_i;
        REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[PIX_W-1:0];
        default:         ;
      endcase
    end
  end

  assign full = fq_full;

  psu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .stream_byte_i (stream_byte_i),
    .image_start_i (image_start_i),
    .row_length_i  (row_length_q),
    .pixel_bytes_i (pixel_bytes_q),
    .q_full_i      (fq_full),
    .q_push_o      (fq_push),
    .q_item_o      (fq_item)
  );

  psu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (bq_take),
    .valid_o (bq_valid),
    .item_o  (bq_item)
  );

  psu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (bq_valid),
    .head_item_i   (bq_item),
    .head_take_o   (bq_take),
    .pixel_bytes_i (pixel_bytes_q),
    .empty_o       (empty),
    .pop_i         (pop),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o),
    .bad_filter_o  (bad_filter_o)
  );

endmodule

// ===== tb/tb_png_scanline_unfilter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter core testbench
// Drives filtered scanline streams through the core and checks every rebuilt
// byte against an in-bench predictor of the five filters. Directed tests
// cover each filter, bad filter codes and a mid-row length change. Further
// tests cover a long receiver stall, long rows of eight-byte pixels and
// random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_png_scanline_unfilter_core;
  import psu_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [BYTE_W-1:0]    stream_byte_i;
  logic                 image_start_i;
  logic                 empty;
  logic                 pop;
  logic [BYTE_W-1:0]    pixel_byte_o;
  logic                 row_end_o;
  logic                 bad_filter_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ROW_LEN_W-1:0] cfg_data_i;

  // Predictor state: a copy of the core's row memory, histories and row tracking
  logic [BYTE_W-1:0]    prev_row [MAX_ROW_BYTES];
  logic [BYTE_W-1:0]    left_hist [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0]    upleft_hist [MAX_PIXEL_BYTES];
  int                   row_col;
  filt_e                cur_filter;
  bit                   want_filter;
  bit                   top_row;
  bit                   dropping;
  logic [ROW_LEN_W-1:0] row_len_reg;
  logic [PIX_W-1:0]     pix_reg;

  // Rebuilt bytes still owed by the core, oldest first
  psu_result_t          pending_pixels[$];

  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   hold_len;
  logic                 hold_on;
  event                 hold_go;

  int                   items_taken;
  int                   pixels_checked;
  int                   bad_filter_seen;
  int                   full_stall_cycles;
  int                   error_count;

  png_scanline_unfilter_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .stream_byte_i (stream_byte_i),
    .image_start_i (image_start_i),
    .empty         (empty),
    .pop           (pop),
    .pixel_byte_o  (pixel_byte_o),
    .row_end_o     (row_end_o),
    .bad_filter_o  (bad_filter_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Paeth predictor: pick the neighbor closest to left + up - upleft
  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    int pa;
    int pb;
    int pc;
    pa = int'(b) - int'(c);
    pb = int'(a) - int'(c);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advance the predictor by one stream byte; returns 1 when a result is due
  function automatic bit rebuild_byte(input logic [BYTE_W-1:0] b, input logic st,
                                      output psu_result_t res);
    int len;
    int pbytes;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] up;
    logic [BYTE_W-1:0] upl;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] v;
    res = '0;
    if (st) begin
      dropping = 1'b0;
      want_filter = 1'b1;
      top_row = 1'b1;
      row_col = 0;
    end
    if (dropping) return 1'b0;
    if (want_filter) begin
      if (b > FILT_MAX_CODE) begin
        dropping = 1'b1;
        res.bad_filter = 1'b1;
        return 1'b1;
      end
      cur_filter = filt_e'(b[2:0]);
      want_filter = 1'b0;
      row_col = 0;
      return 1'b0;
    end
    // Out-of-range register values clamp to the legal range
    len = int'(row_len_reg);
    if (len == 0) len = 1;
    if (len > MAX_ROW_BYTES) len = MAX_ROW_BYTES;
    pbytes = int'(pix_reg);
    if (pbytes == 0) pbytes = 1;
    if (pbytes > MAX_PIXEL_BYTES) pbytes = MAX_PIXEL_BYTES;

    up   = top_row ? '0 : prev_row[row_col];
    left = (row_col >= pbytes) ? left_hist[pbytes-1] : '0;
    upl  = (row_col >= pbytes && !top_row) ? upleft_hist[pbytes-1] : '0;
    case (cur_filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = BYTE_W'((int'(left) + int'(up)) >> 1);
      FILT_PAETH: pred = paeth_pick(left, up, upl);
      default:    pred = '0;
    endcase
    v = b + pred;

    prev_row[row_col] = v;
    for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
      left_hist[i] = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0] = v;
    upleft_hist[0] = up;

    res.pixel_byte = v;
    if (row_col + 1 >= len) begin
      res.row_end = 1'b1;
      row_col = 0;
      want_filter = 1'b1;
      top_row = 1'b0;
    end else begin
      row_col++;
    end
    return 1'b1;
  endfunction

  // Offer one stream byte, hold it until taken, then predict its result
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic st);
    psu_result_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    stream_byte_i <= b;
    image_start_i <= st;
    do @(posedge clk_i); while (full);
    items_taken++;
    if (rebuild_byte(b, st, res)) pending_pixels.push_back(res);
  endtask

  // Wait until the core has delivered everything and gone quiet
  task automatic settle();
    push <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_LEN_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ROW_LENGTH) row_len_reg = val;
    else pix_reg = val[PIX_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] pick_filter();
    if ($urandom_range(99) < 4) return BYTE_W'($urandom_range(5, 255));
    return BYTE_W'($urandom_range(0, 4));
  endfunction

  // Mostly well-formed images with random content, plus broken rows and noise
  task automatic random_stream(input int n_live);
    int live;
    logic [BYTE_W-1:0] b;
    logic st;
    live = 0;
    while (live < n_live) begin
      st = 1'b0;
      if (live == 0) begin
        st = 1'b1;
        b = pick_filter();
      end else if (dropping) begin
        st = ($urandom_range(2) == 0);
        b = st ? pick_filter() : BYTE_W'($urandom);
      end else if (want_filter) begin
        st = ($urandom_range(19) == 0);
        b = pick_filter();
      end else if ($urandom_range(99) == 0) begin
        st = 1'b1;
        b = pick_filter();
      end else begin
        b = BYTE_W'($urandom);
      end
      if (!dropping || st) live++;
      send_byte(b, st);
    end
  endtask

  // Defaults after reset: one-byte rows, one-byte pixels
  task automatic test_reset_defaults();
    send_byte(BYTE_W'(FILT_SUB), 1'b1);
    send_byte(8'hAB, 1'b0);
    send_byte(BYTE_W'(FILT_UP), 1'b0);
    send_byte(8'h01, 1'b0);
    settle();
  endtask

  // Every filter once, with the byte extremes
  task automatic test_each_filter();
    write_reg(REG_ROW_LENGTH, 14'd2);
    write_reg(REG_PIXEL_BYTES, 14'd1);
    send_byte(BYTE_W'(FILT_NONE), 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_W'(FILT_SUB), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(BYTE_W'(FILT_UP), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_W'(FILT_AVG), 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(BYTE_W'(FILT_PAETH), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    settle();
  endtask

  // Bad filter codes: one error result, then drop until the next image start
  task automatic test_bad_filter();
    send_byte(BYTE_W'(FILT_PAETH) + 8'd1, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(BYTE_W'(FILT_NONE), 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(BYTE_W'(FILT_PAETH), 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    settle();
  endtask

  // Row length lowered mid row: the next byte closes the row
  task automatic test_row_shrink();
    write_reg(REG_ROW_LENGTH, 14'd6);
    send_byte(BYTE_W'(FILT_AVG), 1'b1);
    repeat (4) send_byte(BYTE_W'($urandom), 1'b0);
    settle();
    write_reg(REG_ROW_LENGTH, 14'd2);
    send_byte(8'h5A, 1'b0);
    send_byte(BYTE_W'(FILT_PAETH), 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    settle();
  endtask

  // Hold the receiver off while the sender keeps pushing, so full rises
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_ROW_LENGTH, 14'd5);
    write_reg(REG_PIXEL_BYTES, 14'd3);
    hold_len = 200;
    -> hold_go;
    random_stream(60);
    settle();
  endtask

  // Long rows with the widest pixel, eight bytes
  task automatic test_widest_row();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_ROW_LENGTH, 14'd200);
    write_reg(REG_PIXEL_BYTES, 14'd8);
    for (int r = 0; r < 2; r++) begin
      send_byte(BYTE_W'($urandom_range(0, 4)), r == 0);
      repeat (200) send_byte(BYTE_W'($urandom), 1'b0);
    end
    settle();
  endtask

  // Random images under each idle mix, two register settings per mix
  task automatic test_random_traffic();
    logic [ROW_LEN_W-1:0] len;
    logic [PIX_W-1:0] pix;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 0) begin
        len = '0;
        pix = '0;
      end else if (ph == 1) begin
        len = 14'd40;
        pix = '1;
      end else begin
        len = ROW_LEN_W'($urandom_range(1, 32));
        pix = PIX_W'($urandom_range(0, 15));
      end
      write_reg(REG_ROW_LENGTH, len);
      // upper data bits are don't-care for the pixel register
      write_reg(REG_PIXEL_BYTES, {(ROW_LEN_W-PIX_W)'($urandom), pix});
      random_stream(120);
      settle();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Compare one delivered result with the oldest expectation
  task automatic check_pixel();
    psu_result_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected result pixel_byte=%02h row_end=%b bad_filter=%b",
               $time, pixel_byte_o, row_end_o, bad_filter_o);
      error_count++;
    end else begin
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (bad_filter_o === 1'b1) bad_filter_seen++;
      if (pixel_byte_o !== want.pixel_byte) begin
        $display("%0t: pixel_byte mismatch: expected %02h, got %02h",
                 $time, want.pixel_byte, pixel_byte_o);
        error_count++;
      end
      if (row_end_o !== want.row_end) begin
        $display("%0t: row_end mismatch: expected %b, got %b", $time, want.row_end, row_end_o);
        error_count++;
      end
      if (bad_filter_o !== want.bad_filter) begin
        $display("%0t: bad_filter mismatch: expected %b, got %b",
                 $time, want.bad_filter, bad_filter_o);
        error_count++;
      end
    end
  endtask

  // Result side: check each popped result, then pick the next pop at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_pixel();
      pop <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here in cycles
  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (hold_len) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (push && full) full_stall_cycles++;
  end

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    stream_byte_i <= '0;
    image_start_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 0;
    items_taken = 0;
    pixels_checked = 0;
    bad_filter_seen = 0;
    full_stall_cycles = 0;
    error_count = 0;

    // Predictor matches the core's reset state
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
      left_hist[i] = '0;
      upleft_hist[i] = '0;
    end
    row_col = 0;
    cur_filter = FILT_NONE;
    want_filter = 1'b1;
    top_row = 1'b1;
    dropping = 1'b0;
    row_len_reg = ROW_LEN_W'(1);
    pix_reg = PIX_W'(1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_each_filter();
    test_bad_filter();
    test_row_shrink();
    test_backpressure();
    test_widest_row();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d stream bytes and %0d checked results (%0d bad-filter),",
             items_taken, pixels_checked, bad_filter_seen);
    $display("all five filters, rows of 1 to 200 bytes and %0d cycles of input stall.",
             full_stall_cycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
